[rtl/tdps_pkg.sv]
// ----------------------------------------------------------------------------
// tdps_pkg
// shared widths, constants and types of the trial division prime scanner
// ----------------------------------------------------------------------------
package tdps_pkg;

   // payload widths
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 16;

   // trial divisor: d*d <= value < 2**(VALUE_WIDTH-1), plus one step past it
   localparam int DIVISOR_WIDTH  = VALUE_WIDTH / 2 + 1;
   // running square of the divisor, may overshoot the value once
   localparam int SQUARE_WIDTH   = VALUE_WIDTH + 1;
   // bit counter of the serial remainder
   localparam int COUNT_WIDTH    = $clog2(VALUE_WIDTH);

   localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = '1;
   localparam logic [DIVISOR_WIDTH-1:0]  FIRST_DIVISOR = DIVISOR_WIDTH'(2);
   localparam logic [SQUARE_WIDTH-1:0]   FIRST_SQUARE  = SQUARE_WIDTH'(4);

   // one classified item between front and back
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POSITION_WIDTH-1:0]     position;
      logic                          trivial;   // negative, zero or one
   } item_type;

endpackage

[rtl/tdps_if.sv]
// ----------------------------------------------------------------------------
// tdps request and response channels
// valid / ready handshake, payload travels with valid
// ----------------------------------------------------------------------------
interface tdps_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tdps_pkg::VALUE_WIDTH-1:0] value;
   logic                                   start_of_list;

   modport source (output valid, output value, output start_of_list, input ready);
   modport sink   (input valid, input value, input start_of_list, output ready);
endinterface

interface tdps_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tdps_pkg::VALUE_WIDTH-1:0] tested_value;
   logic [tdps_pkg::POSITION_WIDTH-1:0]    position;
   logic                                   is_prime;

   modport source (output valid, output tested_value, output position, output is_prime,
                   input ready);
   modport sink   (input valid, input tested_value, input position, input is_prime,
                   output ready);
endinterface

[rtl/trial_division_prime_scanner_unit.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_scanner_unit
// numbers list values and tests each one for primality by trial division
// ----------------------------------------------------------------------------
// usage
//   req_bus : one beat per list value (signed value, start_of_list)
//   rsp_bus : one beat per request, same order: tested_value, position,
//             is_prime; position restarts at 1 on start_of_list and
//             saturates at its maximum
// operation
//   values below 2 are answered without trial division; otherwise each
//   trial divisor d costs one bound check, then one remainder bit per
//   cycle; the back end also stops as soon as a divisor leaves a zero
//   remainder; the worst case is a large prime, which tries every d
//   with d*d <= value
// throughput
//   one value in flight in the divider; the front takes beats into a
//   two-entry queue while the back end works, so req_bus stalls only
//   when the queue is full
// reset
//   synchronous, clears the position count, queue, engine and rsp valid
// receiver stall
//   the response waits in an output register; the engine starts the next
//   queued value once that register is taken
// ----------------------------------------------------------------------------
module trial_division_prime_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   tdps_req_if.sink   req_bus,
   tdps_rsp_if.source rsp_bus
);

   // front to queue
   logic               push_valid;
   logic               push_ready;
   tdps_pkg::item_type push_item;

   // queue to back
   logic               pop_valid;
   logic               pop_ready;
   tdps_pkg::item_type pop_item;

   // numbering and classification
   tdps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decoupling queue
   tdps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // trial division engine with output register
   tdps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_bus   (rsp_bus)
   );

endmodule

[rtl/tdps_front.sv]
// ----------------------------------------------------------------------------
// tdps_front
// numbers incoming beats and flags the values that need no trial division
// ----------------------------------------------------------------------------
module tdps_front (
   input  logic               clock,
   input  logic               reset,
   tdps_req_if.sink           req_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output tdps_pkg::item_type push_item
);

   logic [tdps_pkg::POSITION_WIDTH-1:0] count_ff, count_in;
   logic                                accept;

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;
   assign accept        = req_bus.valid && push_ready;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_bus.start_of_list) begin
            count_in = tdps_pkg::POSITION_WIDTH'(1);
         end else if (count_ff != tdps_pkg::POSITION_MAX) begin
            count_in = count_ff + tdps_pkg::POSITION_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      push_item.value    = req_bus.value;
      push_item.position = count_in;
      push_item.trivial  = req_bus.value[tdps_pkg::VALUE_WIDTH-1] ||
                           (req_bus.value[tdps_pkg::VALUE_WIDTH-2:0] <
                            (tdps_pkg::VALUE_WIDTH-1)'(2));
   end

endmodule

[rtl/tdps_queue.sv]
// ----------------------------------------------------------------------------
// tdps_queue
// two-entry queue that decouples the front from the back
// ----------------------------------------------------------------------------
module tdps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tdps_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tdps_pkg::item_type pop_item
);

   tdps_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/tdps_back.sv]
// ----------------------------------------------------------------------------
// tdps_back
// trial division engine: serial remainder per divisor, running square bound
// ----------------------------------------------------------------------------
module tdps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  tdps_pkg::item_type pop_item,
   tdps_rsp_if.source         rsp_bus
);

   localparam int VW = tdps_pkg::VALUE_WIDTH;
   localparam int PW = tdps_pkg::POSITION_WIDTH;
   localparam int DW = tdps_pkg::DIVISOR_WIDTH;
   localparam int SW = tdps_pkg::SQUARE_WIDTH;
   localparam int CW = tdps_pkg::COUNT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BOUND = 3'b010,
      ST_DIV   = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [VW-1:0]     val_ff, val_in;
   logic [VW-1:0]     shift_ff, shift_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [DW-1:0]     div_ff, div_in;
   logic [SW-1:0]     sq_ff, sq_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   logic              out_valid_ff, out_valid_in;
   logic [VW-1:0]     out_value_ff, out_value_in;
   logic [PW-1:0]     out_pos_ff, out_pos_in;
   logic              out_prime_ff, out_prime_in;

   logic [DW:0]       trial;
   logic [DW-1:0]     rem_step;

   assign pop_ready = (state_ff == ST_IDLE) && !out_valid_ff;

   // one restoring remainder step
   always_comb begin
      trial = {rem_ff, shift_ff[VW-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = DW'(trial - {1'b0, div_ff});
      end else begin
         rem_step = trial[DW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      shift_in     = shift_ff;
      pos_in       = pos_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_pos_in   = out_pos_ff;
      out_prime_in = out_prime_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && pop_ready) begin
               val_in = pop_item.value;
               pos_in = pop_item.position;
               if (pop_item.trivial) begin
                  out_valid_in = 1'b1;
                  out_value_in = pop_item.value;
                  out_pos_in   = pop_item.position;
                  out_prime_in = 1'b0;
               end else begin
                  div_in   = tdps_pkg::FIRST_DIVISOR;
                  sq_in    = tdps_pkg::FIRST_SQUARE;
                  state_in = ST_BOUND;
               end
            end
         end
         ST_BOUND: begin
            if (sq_ff > {1'b0, val_ff}) begin
               // no divisor left: prime
               out_valid_in = 1'b1;
               out_value_in = val_ff;
               out_pos_in   = pos_ff;
               out_prime_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rem_in   = '0;
               shift_in = val_ff;
               cnt_in   = CW'(VW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = rem_step;
            shift_in = {shift_ff[VW-2:0], 1'b0};
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (rem_step == '0) begin
                  out_valid_in = 1'b1;
                  out_value_in = val_ff;
                  out_pos_in   = pos_ff;
                  out_prime_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  div_in   = div_ff + DW'(1);
                  sq_in    = sq_ff + SW'({div_ff, 1'b1});
                  state_in = ST_BOUND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      shift_ff     <= shift_in;
      pos_ff       <= pos_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_pos_ff   <= out_pos_in;
      out_prime_ff <= out_prime_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.tested_value = $signed(out_value_ff);
   assign rsp_bus.position     = out_pos_ff;
   assign rsp_bus.is_prime     = out_prime_ff;

endmodule

[rtl/tdps_checker.sv]
// ----------------------------------------------------------------------------
// tdps_checker
// port-level checks of the prime scanner, bound to the top level
// ----------------------------------------------------------------------------
module tdps_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [tdps_pkg::VALUE_WIDTH-1:0] rsp_tested_value,
   input logic [tdps_pkg::POSITION_WIDTH-1:0]    rsp_position,
   input logic                                   rsp_is_prime
);

   // no response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // a stalled beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_tested_value) && $stable(rsp_position) &&
                                  $stable(rsp_is_prime))
      else $error("rsp payload changed while stalled");

   // primes are at least 2
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_tested_value > 1)
      else $error("prime flag on a value below 2");

   // the only even prime is 2, and position never reads 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position != '0) &&
                    (!rsp_is_prime || rsp_tested_value[0] ||
                     rsp_tested_value == tdps_pkg::VALUE_WIDTH'(2)))
      else $error("even prime above 2 or zero position");

endmodule

bind trial_division_prime_scanner_unit tdps_checker u_tdps_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_tested_value (rsp_bus.tested_value),
   .rsp_position     (rsp_bus.position),
   .rsp_is_prime     (rsp_bus.is_prime)
);
